[hw/rtl/rwu_pkg.sv]
package rwu_pkg;

  localparam int unsigned SlotsDef   = 1024;
  localparam int unsigned SlotW      = 10;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned SqrtSteps  = 24;  // 48-bit radicand, 2 bits a step
  localparam int unsigned DivSteps   = 48;  // 48-bit dividend, 1 bit a step
  localparam logic [CfgW-1:0] DecayRst = 16'd58982;
  localparam logic [CfgW-1:0] LrRst    = 16'd66;

  localparam logic [CfgIdxW-1:0] RegDecay = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLr    = 1'b1;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] weight;
    logic             neg;
  } rwu_tag_t;

endpackage

[hw/rtl/rwu_ram.sv]
module rwu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/rwu_sqrt.sv]
// Pipelined restoring square root of a 48-bit radicand, one result bit per stage.
module rwu_sqrt import rwu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] v_i,
  input  logic [31:0] num_i,
  input  rwu_tag_t    tag_i,
  output logic        valid_o,
  output logic [24:0] root_o,
  output logic [31:0] num_o,
  output rwu_tag_t    tag_o
);

  logic [SqrtSteps:0]   vld_q;
  logic [47:0]          rem_q  [SqrtSteps+1];
  logic [23:0]          res_q  [SqrtSteps+1];
  logic [47:0]          rad_q  [SqrtSteps+1];
  logic [31:0]          num_q  [SqrtSteps+1];
  rwu_tag_t             tag_q  [SqrtSteps+1];

  always_comb begin
    rem_q[0] = '0;
    res_q[0] = '0;
    rad_q[0] = {v_i, 16'h0000};
    num_q[0] = num_i;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic [49:0] trial;
    logic [47:0] rem_sh;
    assign rem_sh = {rem_q[k][45:0], rad_q[k][47:46]};
    assign trial  = {2'b00, rem_sh} - {24'h0, res_q[k], 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1] <= {rad_q[k][45:0], 2'b00};
        num_q[k+1] <= num_q[k];
        tag_q[k+1] <= tag_q[k];
        if (!trial[49]) begin
          rem_q[k+1] <= trial[47:0];
          res_q[k+1] <= {res_q[k][22:0], 1'b1};
        end else begin
          rem_q[k+1] <= rem_sh;
          res_q[k+1] <= {res_q[k][22:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign root_o  = {1'b0, res_q[SqrtSteps]} + 25'd1;
  assign num_o   = num_q[SqrtSteps];
  assign tag_o   = tag_q[SqrtSteps];

endmodule

[hw/rtl/rwu_div.sv]
// Pipelined restoring divider: 48-bit dividend over a 25-bit divisor, one quotient bit per stage,
// then sign and saturating subtract from the weight.
module rwu_div import rwu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [47:0]      dvd_i,
  input  logic [24:0]      dvs_i,
  input  rwu_tag_t         tag_i,
  output logic             valid_o,
  output logic [SlotW-1:0] slot_o,
  output logic [DataW-1:0] weight_o
);

  logic [DivSteps:0] vld_q;
  logic [25:0]       rem_q [DivSteps+1];
  logic [47:0]       quo_q [DivSteps+1];
  logic [24:0]       dvs_q [DivSteps+1];
  rwu_tag_t          tag_q [DivSteps+1];
  logic              out_vld_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [DataW-1:0]  out_w_q;

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = '0;
    quo_q[0] = dvd_i;
    dvs_q[0] = dvs_i;
    tag_q[0] = tag_i;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [25:0] sh;
    logic [26:0] trial;
    assign sh    = {rem_q[k][24:0], quo_q[k][47]};
    assign trial = {1'b0, sh} - {2'b00, dvs_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[k+1] <= dvs_q[k];
        tag_q[k+1] <= tag_q[k];
        if (!trial[26]) begin
          rem_q[k+1] <= trial[25:0];
          quo_q[k+1] <= {quo_q[k][46:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh;
          quo_q[k+1] <= {quo_q[k][46:0], 1'b0};
        end
      end
    end
  end

  logic signed [49:0] step;
  logic signed [49:0] res;
  logic [DataW-1:0]   sat;
  rwu_tag_t           tl;

  always_comb begin
    tl   = tag_q[DivSteps];
    step = tl.neg ? -$signed({2'b00, quo_q[DivSteps]}) : $signed({2'b00, quo_q[DivSteps]});
    res  = $signed({{18{tl.weight[DataW-1]}}, tl.weight}) - step;
    if (res > 50'sh7FFFFFFF) begin
      sat = 32'h7FFFFFFF;
    end else if (res < -50'sh80000000) begin
      sat = 32'h80000000;
    end else begin
      sat = res[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_slot_q <= tl.slot;
      out_w_q    <= sat;
    end
  end

  assign valid_o  = out_vld_q;
  assign slot_o   = out_slot_q;
  assign weight_o = out_w_q;

endmodule

[hw/rtl/rmsprop_weight_update_top.sv]
// Throughput: one beat per cycle; the whole pipeline advances together and holds on a stall.
// Most of the depth is in the 24-stage root and the 48-stage divider, one bit per stage each.
// Reset clears the valid bits and sets the config registers to their defaults, then a clearing pass
// zeroes the mean-square store one entry a cycle with s_axis_tready low.
module rmsprop_weight_update_top import rwu_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [79:0]        s_axis_tdata,   // slot[9:0], weight_in[41:10], gradient[73:42]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // slot_out[9:0], weight_out[41:10]
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = (Slots > 1) ? $clog2(Slots) : 1;

  logic [CfgW-1:0] decay_q, lr_q;
  logic            en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayRst;
      lr_q    <= LrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDecay: decay_q <= cfg_data_i;
        RegLr:    lr_q    <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Zero the store after reset, one entry a cycle.
  logic [AddrW-1:0] clr_addr_q;
  logic             clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(Slots - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Output register is the last stage; advance everything when it is free.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !clr_busy_q;

  logic             acc;
  logic [SlotW-1:0] in_slot;
  logic [DataW-1:0] in_w, in_g;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign in_slot = s_axis_tdata[9:0];
  assign in_w    = s_axis_tdata[41:10];
  assign in_g    = s_axis_tdata[73:42];

  logic             in_rng;
  assign in_rng = ({22'h0, in_slot} < 32'(Slots));

  // Stage 1: |g| and store read.
  logic             s1_vld_q, s1_rng_q;
  logic [SlotW-1:0] s1_slot_q;
  logic [DataW-1:0] s1_w_q, s1_gm_q;
  logic             s1_neg_q;
  // Stage 2: g*g.
  logic             s2_vld_q, s2_rng_q;
  logic [SlotW-1:0] s2_slot_q;
  logic [DataW-1:0] s2_w_q, s2_gm_q, s2_v_q;
  logic             s2_neg_q;
  logic [63:0]      s2_sq_q;
  // Stage 3: decay products.
  logic             s3_vld_q, s3_rng_q;
  logic [SlotW-1:0] s3_slot_q;
  logic [DataW-1:0] s3_w_q, s3_gm_q;
  logic             s3_neg_q;
  logic [47:0]      s3_pa_q, s3_pb_q;
  // Stage 4: new average and |g|.
  logic             s4_vld_q, s4_rng_q;
  logic [SlotW-1:0] s4_slot_q;
  logic [DataW-1:0] s4_w_q, s4_v_q, s4_num_q;
  logic             s4_neg_q;

  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] v_fwd;
  logic             wr_en;
  logic [DataW-1:0] nv;
  logic [48:0]      nv_sum;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             st_we;
  logic [AddrW-1:0] st_waddr;
  logic [DataW-1:0] st_wdata;

  // Bypass: the store write lags the read by three stages.
  logic             s2_hit3;
  logic [DataW-1:0] nv_s4_pipe;

  assign rd_addr  = AddrW'(in_slot);
  assign wr_addr  = AddrW'(s3_slot_q);
  assign st_we    = clr_busy_q || wr_en;
  assign st_waddr = clr_busy_q ? clr_addr_q : wr_addr;
  assign st_wdata = clr_busy_q ? '0 : nv;

  rwu_ram #(.Width(DataW), .Depth(Slots)) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
    end else if (en) begin
      s1_vld_q <= acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Newest in-flight value for the slot in stage 1 (stage 3/4 items whose write the read did not see).
  logic hit2, hit3, hit4;
  assign hit2 = s2_vld_q && s2_rng_q && (s2_slot_q == s1_slot_q);
  assign hit3 = s3_vld_q && s3_rng_q && (s3_slot_q == s1_slot_q);
  assign hit4 = s4_vld_q && s4_rng_q && (s4_slot_q == s1_slot_q);

  logic [DataW-1:0] wb_q; // value written by the item now in stage 4
  assign s2_hit3 = hit2;
  assign nv_s4_pipe = wb_q;

  always_comb begin
    if (!s1_rng_q) begin
      v_fwd = '0;
    end else if (hit3) begin
      v_fwd = nv;
    end else if (hit4) begin
      v_fwd = nv_s4_pipe;
    end else begin
      v_fwd = rd_data;
    end
  end

  // Item in stage 2 with the same slot is resolved once both have moved on a stage: hold a flag.
  logic s2_dep_q;

  logic [DataW-1:0] gmag;
  assign gmag = in_g[DataW-1] ? (~in_g + 32'd1) : in_g;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rng_q  <= in_rng;
      s1_slot_q <= in_slot;
      s1_w_q    <= in_w;
      s1_gm_q   <= gmag;
      s1_neg_q  <= in_g[DataW-1];

      s2_rng_q  <= s1_rng_q;
      s2_slot_q <= s1_slot_q;
      s2_w_q    <= s1_w_q;
      s2_gm_q   <= s1_gm_q;
      s2_neg_q  <= s1_neg_q;
      s2_v_q    <= v_fwd;
      s2_dep_q  <= s2_hit3;
      s2_sq_q   <= 64'(s1_gm_q) * 64'(s1_gm_q);

      s3_rng_q  <= s2_rng_q;
      s3_slot_q <= s2_slot_q;
      s3_w_q    <= s2_w_q;
      s3_gm_q   <= s2_gm_q;
      s3_neg_q  <= s2_neg_q;
      s3_pa_q   <= 48'(decay_q) * 48'(s2_dep_q ? nv : s2_v_q);
      s3_pb_q   <= 48'(17'h10000 - {1'b0, decay_q}) *
                   48'((s2_sq_q[63:48] != 16'h0) ? 32'hFFFFFFFF : s2_sq_q[47:16]);

      s4_rng_q  <= s3_rng_q;
      s4_slot_q <= s3_slot_q;
      s4_w_q    <= s3_w_q;
      s4_v_q    <= nv;
      s4_neg_q  <= s3_neg_q;
      s4_num_q  <= 32'(s3_gm_q);
      wb_q      <= nv;
    end
  end

  assign nv_sum = {1'b0, s3_pa_q} + {1'b0, s3_pb_q};
  assign nv     = (nv_sum[48]) ? 32'hFFFFFFFF : nv_sum[47:16];
  assign wr_en  = en && s3_vld_q && s3_rng_q;

  // lr*|g| is formed after the root so the multiply stays registered.
  logic             q_vld;
  logic [24:0]      root;
  logic [31:0]      gm_sq;
  rwu_tag_t         tag_in, tag_q;
  logic [47:0]      prod_q;
  logic [24:0]      root_q;
  rwu_tag_t         tag2_q;
  logic             vld2_q;

  assign tag_in = '{slot: s4_slot_q, weight: s4_w_q, neg: s4_neg_q};

  rwu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s4_vld_q),
    .v_i    (s4_v_q),
    .num_i  (s4_num_q),
    .tag_i  (tag_in),
    .valid_o(q_vld),
    .root_o (root),
    .num_o  (gm_sq),
    .tag_o  (tag_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 48'(lr_q) * 48'(gm_sq);
      root_q <= root;
      tag2_q <= tag_q;
    end
  end

  logic [SlotW-1:0] o_slot;
  logic [DataW-1:0] o_w;

  rwu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld2_q),
    .dvd_i   (prod_q),
    .dvs_i   (root_q),
    .tag_i   (tag2_q),
    .valid_o (m_axis_tvalid),
    .slot_o  (o_slot),
    .weight_o(o_w)
  );

  assign m_axis_tdata = {6'h0, o_w, o_slot};

endmodule

[hw/rtl/rwu_checker.sv]
module rwu_checker import rwu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tready |=> s_axis_tready || m_axis_tvalid)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:42] == 6'h0) else $error("tdata pad not zero");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept during stall");

endmodule

bind rmsprop_weight_update_top rwu_checker u_rwu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[sim/rmsprop_weight_update_top_test.sv]
module rmsprop_weight_update_top_test;
  import rwu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency = 77;

  // Expected updates and the golden copy of the mean-square store
  class rmsprop_scoreboard;
    logic [47:0] pending_q[$];
    logic [31:0] msq_mem[SlotsDef];
    logic [15:0] decay;
    logic [15:0] lr;
    int errors;
    int updates;

    function void clear();
      foreach (msq_mem[i]) msq_mem[i] = '0;
      decay = DecayRst;
      lr = LrRst;
      errors = 0;
      updates = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == RegDecay) decay = val;
      else if (idx == RegLr) lr = val;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_input(logic [79:0] beat);
      logic [9:0] slot;
      longint w, g, r, step;
      longint unsigned v, gmag, gsq, nv, d, smag;
      bit in_range;
      slot = beat[9:0];
      w = longint'($signed(beat[41:10]));
      g = longint'($signed(beat[73:42]));
      in_range = slot < SlotsDef;
      v = in_range ? msq_mem[slot] : 0;
      gmag = (g < 0) ? longint'(-g) : g;
      gsq = (gmag * gmag) >> 16;
      if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
      nv = (64'(decay) * v + (64'd65536 - 64'(decay)) * gsq) >> 16;
      if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
      if (in_range) msq_mem[slot] = nv[31:0];
      d = int_sqrt(nv << 16) + 1;
      smag = (64'(lr) * gmag) / d;
      step = (g < 0) ? -longint'(smag) : longint'(smag);
      r = w - step;
      if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
      if (r < -64'sh8000_0000) r = -64'sh8000_0000;
      pending_q.push_back({6'd0, r[31:0], slot});
    endfunction

    function void check_result(logic [47:0] beat);
      logic [47:0] exp_beat;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected update slot %0d weight %h", $realtime, beat[9:0],
                 beat[41:10]);
        errors++;
        return;
      end
      exp_beat = pending_q.pop_front();
      updates++;
      if (beat[9:0] !== exp_beat[9:0]) begin
        $display("%0t: slot_out expected %0d actual %0d", $realtime, exp_beat[9:0],
                 beat[9:0]);
        errors++;
      end
      if (beat[41:10] !== exp_beat[41:10]) begin
        $display("%0t: weight_out expected %h actual %h", $realtime, exp_beat[41:10],
                 beat[41:10]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // slot[9:0], weight_in[41:10], gradient[73:42]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // slot_out[9:0], weight_out[41:10]
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  rmsprop_scoreboard sb = new();
  bit calm;  // no idling in the last part
  int sent;

  always #5 clk_i = ~clk_i;

  rmsprop_weight_update_top dut (.*);

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stall bursts, check at the rising edge
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_beat(logic [9:0] slot, logic [31:0] w, logic [31:0] g);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, g, w, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input({6'd0, g, w, slot});
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [15:0] decays[4] = '{16'd0, 16'd65535, 16'd58982, 16'd32768};
    logic [15:0] rates[4] = '{16'd65535, 16'd0, 16'd66, 16'd4000};
    logic [31:0] wextr[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    logic [31:0] w;
    sb.clear();
    sent = 0;
    calm = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes at reset settings, then large lr for saturation, then lr of zero
    foreach (wextr[i]) send_beat(10'(i), wextr[i], 32'h8000_0000);
    foreach (wextr[i]) send_beat(10'h3FF - 10'(i), wextr[i], 32'h7FFF_FFFF);
    send_beat(10'd5, 32'h0001_0000, 32'h0);
    send_beat(10'd5, 32'h0001_0000, 32'h0000_0001);
    drain();
    write_reg(RegLr, 16'hFFFF);
    write_reg(RegDecay, 16'd0);
    send_beat(10'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(10'd8, 32'h8000_0000, 32'h0000_0001);
    send_beat(10'd9, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(10'd9, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(RegLr, 16'd0);
    send_beat(10'd1, 32'h1234_5678, 32'h0400_0000);
    send_beat(10'd1, 32'h8765_4321, 32'hC000_0000);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(RegDecay, ph < 4 ? decays[ph] : 16'($urandom));
      write_reg(RegLr, ph < 4 ? rates[ph] : 16'($urandom_range(0, 8000)));
      if (ph == 11) calm = 1;
      for (int k = 0; k < 135; k++) begin
        w = ($urandom_range(0, 7) == 0) ? wextr[$urandom_range(0, 3)]
                                         : 32'($signed($urandom_range(0, 32'h00FF_FFFF))
                                               - 32'sh0080_0000);
        // few hot slots so averages build up
        send_beat($urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom), w,
                  rand_grad());
      end
      drain();
    end

    calm = 1;
    repeat (Latency + 20) @(negedge clk_i);
    $display("Ran %0d updates over 15 register settings, extremes and saturation included.",
             sent);
    $display("Checked %0d results field by field.", sb.updates);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[rmsprop_weight_update_top.f]
hw/rtl/rwu_pkg.sv
hw/rtl/rwu_ram.sv
hw/rtl/rwu_sqrt.sv
hw/rtl/rwu_div.sv
hw/rtl/rmsprop_weight_update_top.sv
hw/rtl/rwu_checker.sv
sim/rmsprop_weight_update_top_test.sv
